>>> design/clcd_pkg.sv
// Shared constants, codes and types for the character LCD write sequencer.
package clcd_pkg;

  // Default display width in characters per line
  localparam int unsigned CLCD_COLUMNS = 16;

  // Item fields and configuration port sizes
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LINE_W    = 2;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 5;
  localparam int unsigned NUM_SLOTS = 3;

  // Nibble masks for the four-bit bus
  localparam logic [BYTE_W-1:0] HI_NIB_MASK = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] LO_NIB_MASK = 8'b0000_1111;

  // Configuration register defaults
  localparam logic [BYTE_W-1:0]  FIRST_BASE_RST  = 8'd128;
  localparam logic [BYTE_W-1:0]  SECOND_BASE_RST = 8'd192;
  localparam logic [BYTE_W-1:0]  CLEAR_CODE_RST  = 8'd1;
  localparam logic [TICKS_W-1:0] PULSE_TICKS_RST = 16'd100;
  localparam logic [TICKS_W-1:0] WAIT_TICKS_RST  = 16'd1000;

  // Register select values on the LCD bus
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Input item kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_CHAR  = 2'd0,
    ACT_CMD   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_GOTO  = 2'd3
  } action_t;

  // Configuration register indexes (byte address bits 4:2)
  typedef enum logic [2:0] {
    REG_BUS_MODE    = 3'd0,
    REG_FIRST_BASE  = 3'd1,
    REG_SECOND_BASE = 3'd2,
    REG_CLEAR_CODE  = 3'd3,
    REG_PULSE_TICKS = 3'd4,
    REG_WAIT_TICKS  = 3'd5
  } reg_idx_t;

  // Byte list built for one accepted item, emitted slot 0 first
  typedef struct packed {
    logic [NUM_SLOTS-1:0][BYTE_W-1:0] bytes;
    logic [NUM_SLOTS-1:0]             rs;
    logic [1:0]                       last_slot;
    logic                             nibble_mode;
  } plan_t;

endpackage

>>> design/clcd_ifs.sv
// Valid/ready channel interfaces for sequencer items and LCD bus transfers.
interface clcd_in_if import clcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   byte_value;
  logic [LINE_W-1:0]   line_select;
  logic [BYTE_W-1:0]   column_position;
  logic                string_start;

  modport source (output valid, action, byte_value, line_select, column_position,
                  string_start, input ready);
  modport sink   (input valid, action, byte_value, line_select, column_position,
                  string_start, output ready);
endinterface

interface clcd_out_if import clcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              register_select;
  logic [BYTE_W-1:0] bus_value;
  logic              last;

  modport source (output valid, register_select, bus_value, last, input ready);
  modport sink   (input valid, register_select, bus_value, last, output ready);
endinterface

>>> design/char_lcd_write_sequencer.sv
// Top level of the character LCD write sequencer: decode, plan register and transfer emitter.
//
// Usage:
//   in_ch  takes one item per transaction: a string character, a raw command,
//          a clear screen or a goto (line, column).
//   out_ch gives LCD bus transfers (register select, bus byte, last). In
//          eight-bit mode each byte is one transfer; in four-bit mode it is
//          the upper nibble then the lower nibble, both on bits 7:4.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready is the register port;
//          register i sits at byte address 4*i. Write it only while idle.
// Timing: the first transfer of an item is valid the cycle after it is
//   accepted. One transfer per cycle while out_ch.ready is high; an item gives
//   up to three bytes, two transfers each in four-bit mode. An item with no
//   transfer, such as a goto out of range, leaves no plan pending. The next
//   item is accepted in the cycle its predecessor's last transfer is taken.
// Reset: clears the character count, the line-two flag, the pending plan and
//   sets all registers to their defaults.
// Stall: while out_ch.ready is low the current transfer holds and in_ch.ready
//   stays low once a plan is pending.
module char_lcd_write_sequencer import clcd_pkg::*; #(
  parameter int unsigned COLUMNS = CLCD_COLUMNS
) (
  input  logic              clk,
  input  logic              rst_n,
  clcd_in_if.sink           in_ch,
  clcd_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int unsigned CNT_W = $clog2(2 * COLUMNS + 1);
  localparam logic [CNT_W-1:0]  COL_LIM  = CNT_W'(COLUMNS);
  localparam logic [CNT_W-1:0]  FULL_LIM = CNT_W'(2 * COLUMNS);
  localparam logic [BYTE_W-1:0] COL_MAX  = BYTE_W'(COLUMNS);

  // Configuration registers
  logic               bus_mode_r;
  logic [BYTE_W-1:0]  first_base_r;
  logic [BYTE_W-1:0]  second_base_r;
  logic [BYTE_W-1:0]  clear_code_r;
  logic [TICKS_W-1:0] pulse_ticks_r;
  logic [TICKS_W-1:0] wait_ticks_r;

  // String state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             line2_r, line2_nxt;

  // Pending plan and emitter position
  plan_t      plan_r, plan_nxt;
  logic       valid_r;
  logic [1:0] slot_r;
  logic       phase_r;

  logic             in_acc, out_acc, is_last, plan_has;
  logic [CNT_W-1:0] cnt_eff;
  logic             line2_eff;
  reg_idx_t         reg_idx;
  logic [BYTE_W-1:0] cur_byte;

  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign pready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_mode_r    <= 1'b0;
      first_base_r  <= FIRST_BASE_RST;
      second_base_r <= SECOND_BASE_RST;
      clear_code_r  <= CLEAR_CODE_RST;
      pulse_ticks_r <= PULSE_TICKS_RST;
      wait_ticks_r  <= WAIT_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_BUS_MODE:    bus_mode_r    <= pwdata[0];
        REG_FIRST_BASE:  first_base_r  <= pwdata[BYTE_W-1:0];
        REG_SECOND_BASE: second_base_r <= pwdata[BYTE_W-1:0];
        REG_CLEAR_CODE:  clear_code_r  <= pwdata[BYTE_W-1:0];
        REG_PULSE_TICKS: pulse_ticks_r <= pwdata[TICKS_W-1:0];
        REG_WAIT_TICKS:  wait_ticks_r  <= pwdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BUS_MODE:    prdata = APB_DW'(bus_mode_r);
      REG_FIRST_BASE:  prdata = APB_DW'(first_base_r);
      REG_SECOND_BASE: prdata = APB_DW'(second_base_r);
      REG_CLEAR_CODE:  prdata = APB_DW'(clear_code_r);
      REG_PULSE_TICKS: prdata = APB_DW'(pulse_ticks_r);
      REG_WAIT_TICKS:  prdata = APB_DW'(wait_ticks_r);
      default:         prdata = '0;
    endcase
  end

  // Current transfer
  assign cur_byte = plan_r.bytes[slot_r];
  assign is_last  = (slot_r == plan_r.last_slot) && (!plan_r.nibble_mode || phase_r);

  always_comb begin
    out_ch.valid           = valid_r;
    out_ch.register_select = plan_r.rs[slot_r];
    out_ch.last            = is_last;
    if (!plan_r.nibble_mode) begin
      out_ch.bus_value = cur_byte;
    end else if (phase_r) begin
      out_ch.bus_value = {cur_byte[3:0], 4'b0000};
    end else begin
      out_ch.bus_value = cur_byte & HI_NIB_MASK;
    end
  end

  assign out_acc     = valid_r && out_ch.ready;
  assign in_ch.ready = !valid_r || (out_ch.ready && is_last);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Decode the incoming item into a byte list and the next string state
  assign cnt_eff   = in_ch.string_start ? '0 : cnt_r;
  assign line2_eff = in_ch.string_start ? 1'b0 : line2_r;

  always_comb begin
    plan_nxt             = '0;
    plan_nxt.nibble_mode = bus_mode_r;
    plan_has             = 1'b1;
    cnt_nxt              = cnt_r;
    line2_nxt            = line2_r;
    case (action_t'(in_ch.action))
      ACT_CHAR: begin
        if (cnt_eff >= COL_LIM && cnt_eff < FULL_LIM && !line2_eff) begin
          plan_nxt.bytes[0]  = second_base_r;
          plan_nxt.bytes[1]  = in_ch.byte_value;
          plan_nxt.rs[1]     = RS_DATA;
          plan_nxt.last_slot = 2'd1;
          cnt_nxt            = cnt_eff + CNT_W'(1);
          line2_nxt          = 1'b1;
        end else if (cnt_eff >= FULL_LIM) begin
          plan_nxt.bytes[0]  = clear_code_r;
          plan_nxt.bytes[1]  = first_base_r;
          plan_nxt.bytes[2]  = in_ch.byte_value;
          plan_nxt.rs[2]     = RS_DATA;
          plan_nxt.last_slot = 2'd2;
          cnt_nxt            = CNT_W'(1);
          line2_nxt          = 1'b0;
        end else begin
          plan_nxt.bytes[0]  = in_ch.byte_value;
          plan_nxt.rs[0]     = RS_DATA;
          cnt_nxt            = cnt_eff + CNT_W'(1);
          line2_nxt          = line2_eff;
        end
      end
      ACT_CMD: begin
        plan_nxt.bytes[0] = in_ch.byte_value;
      end
      ACT_CLEAR: begin
        plan_nxt.bytes[0]  = clear_code_r;
        plan_nxt.bytes[1]  = first_base_r;
        plan_nxt.last_slot = 2'd1;
      end
      default: begin
        // Drop a goto outside the display
        plan_has = (in_ch.column_position < COL_MAX) && (in_ch.line_select <= 2'd1);
        plan_nxt.bytes[0] = ((in_ch.line_select == 2'd0) ? first_base_r : second_base_r)
                            + in_ch.column_position;
      end
    endcase
  end

  // String state advances on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      line2_r <= 1'b0;
    end else if (in_acc) begin
      cnt_r   <= cnt_nxt;
      line2_r <= line2_nxt;
    end
  end

  // Load a new plan, or advance through the pending one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      slot_r  <= '0;
      phase_r <= 1'b0;
    end else if (in_acc) begin
      valid_r <= plan_has;
      slot_r  <= '0;
      phase_r <= 1'b0;
    end else if (out_acc) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end else if (plan_r.nibble_mode && !phase_r) begin
        phase_r <= 1'b1;
      end else begin
        phase_r <= 1'b0;
        slot_r  <= slot_r + 2'd1;
      end
    end
  end

  // Hold plan payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      plan_r <= plan_nxt;
    end
  end

  // Emitter never runs past the final slot of its plan
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> slot_r <= plan_r.last_slot)
    else $error("emitter slot beyond plan");

  // Lower-nibble phase only exists on the four-bit bus
  a_phase_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && phase_r) |-> plan_r.nibble_mode)
    else $error("nibble phase in eight-bit mode");

  // Character count stays within two lines
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_LIM)
    else $error("character count out of range");

  // Final transfer taken with no new item empties the emitter
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && is_last && !in_acc) |=> !valid_r)
    else $error("plan still pending after last transfer");

  // A stalled transfer keeps the emitter position and stays valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |=> ($stable(slot_r) && $stable(phase_r) && valid_r))
    else $error("emitter moved while stalled");

endmodule

>>> test/tb_char_lcd_write_sequencer.sv
// Self-checking testbench for the character LCD write sequencer.
`timescale 1ns / 100ps

module tb_char_lcd_write_sequencer;
  import clcd_pkg::*;

  localparam int unsigned NUM_REGS       = 6;
  localparam int          FROM_PREDICTOR = -1;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          LONG_HOLD      = 300;

  // One LCD bus transfer
  typedef struct packed {
    logic              rs;
    logic [BYTE_W-1:0] value;
    logic              last;
  } xfer_t;

  // One sequencer request
  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] byte_value;
    logic [LINE_W-1:0] line_sel;
    logic [BYTE_W-1:0] column;
    logic              string_start;
  } lcd_item_t;

  // Directed row: request plus transfers typed in by hand, or taken from the predictor
  typedef struct {
    lcd_item_t item;
    int        n_typed;
    xfer_t     typed [2];
  } stim_row_t;

  localparam xfer_t NO_XFER = '{1'b0, 8'h00, 1'b0};

  logic clk = 1'b0;
  logic rst_n;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  clcd_in_if  in_ch ();
  clcd_out_if out_ch ();

  char_lcd_write_sequencer u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Register copies held by the predictor
  logic               cfg_four_bit    = 1'b0;
  logic [BYTE_W-1:0]  cfg_first_base  = FIRST_BASE_RST;
  logic [BYTE_W-1:0]  cfg_second_base = SECOND_BASE_RST;
  logic [BYTE_W-1:0]  cfg_clear_code  = CLEAR_CODE_RST;
  logic [TICKS_W-1:0] cfg_pulse_ticks = PULSE_TICKS_RST;
  logic [TICKS_W-1:0] cfg_wait_ticks  = WAIT_TICKS_RST;

  // Display state held by the predictor
  logic [5:0] chars_in_string = '0;
  logic       wrapped_to_line2 = 1'b0;

  // Transfers planned for the latest request, and those still owed by the block
  xfer_t planned_xfers [6];
  int    planned_len;
  xfer_t pending_transfers [$];

  int errors = 0;
  int productive_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int long_hold_seq = 0;

  stim_row_t stim_table [17] = '{
    '{'{ACT_CHAR,  8'h41, 2'd0, 8'h00, 1'b1}, 1,
      '{'{RS_DATA, 8'h41, 1'b1}, NO_XFER}},
    '{'{ACT_CHAR,  8'hFF, 2'd3, 8'hFF, 1'b0}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}},
    '{'{ACT_CHAR,  8'h00, 2'd0, 8'h00, 1'b0}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}},
    '{'{ACT_CMD,   8'h00, 2'd0, 8'h00, 1'b0}, 1,
      '{'{RS_CMD, 8'h00, 1'b1}, NO_XFER}},
    '{'{ACT_CMD,   8'hFF, 2'd0, 8'h00, 1'b0}, 1,
      '{'{RS_CMD, 8'hFF, 1'b1}, NO_XFER}},
    '{'{ACT_CLEAR, 8'h00, 2'd0, 8'h00, 1'b0}, 2,
      '{'{RS_CMD, CLEAR_CODE_RST, 1'b0}, '{RS_CMD, FIRST_BASE_RST, 1'b1}}},
    '{'{ACT_GOTO,  8'h00, 2'd0, 8'd0,  1'b0}, 1,
      '{'{RS_CMD, FIRST_BASE_RST, 1'b1}, NO_XFER}},
    '{'{ACT_GOTO,  8'h00, 2'd1, 8'd15, 1'b0}, 1,
      '{'{RS_CMD, 8'hCF, 1'b1}, NO_XFER}},
    // out-of-range gotos give no transfer
    '{'{ACT_GOTO,  8'h00, 2'd1, 8'd16,  1'b0}, 0, '{NO_XFER, NO_XFER}},
    '{'{ACT_GOTO,  8'hFF, 2'd2, 8'd0,   1'b1}, 0, '{NO_XFER, NO_XFER}},
    '{'{ACT_GOTO,  8'h00, 2'd3, 8'd255, 1'b0}, 0, '{NO_XFER, NO_XFER}},
    '{'{ACT_GOTO,  8'h00, 2'd0, 8'd255, 1'b0}, 0, '{NO_XFER, NO_XFER}},
    // string start on non-character requests is ignored; on a character it restarts the string
    '{'{ACT_CMD,   8'h55, 2'd3, 8'hFF, 1'b1}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}},
    '{'{ACT_CLEAR, 8'hFF, 2'd3, 8'hFF, 1'b1}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}},
    '{'{ACT_CHAR,  8'hAA, 2'd1, 8'd7,  1'b1}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}},
    '{'{ACT_GOTO,  8'hFF, 2'd1, 8'd0,  1'b1}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}},
    '{'{ACT_CHAR,  8'h5A, 2'd2, 8'hF0, 1'b0}, FROM_PREDICTOR, '{NO_XFER, NO_XFER}}
  };

  // Clock and reset
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // Predictor: append one transfer to the plan
  function void plan_xfer(input logic rs, input logic [BYTE_W-1:0] value);
    planned_xfers[planned_len] = '{rs, value, 1'b0};
    planned_len++;
  endfunction

  // Predictor: split a byte into nibbles on the narrow bus
  function void plan_byte(input logic rs, input logic [BYTE_W-1:0] b);
    if (cfg_four_bit) begin
      plan_xfer(rs, b & HI_NIB_MASK);
      plan_xfer(rs, (b & LO_NIB_MASK) << 4);
    end else begin
      plan_xfer(rs, b);
    end
  endfunction

  // Predictor: set-address command, skipped for bad line or column
  function void plan_goto(input logic [LINE_W-1:0] ln, input logic [BYTE_W-1:0] col);
    if (col < CLCD_COLUMNS) begin
      if (ln == 2'd0) plan_byte(RS_CMD, cfg_first_base + col);
      else if (ln == 2'd1) plan_byte(RS_CMD, cfg_second_base + col);
    end
  endfunction

  // Predictor: work out the transfers of one request and advance the display state
  function void plan_bus_transfers(input lcd_item_t it);
    planned_len = 0;
    case (it.action)
      ACT_CHAR: begin
        if (it.string_start) begin
          chars_in_string = '0;
          wrapped_to_line2 = 1'b0;
        end
        if (chars_in_string >= CLCD_COLUMNS && chars_in_string < 2 * CLCD_COLUMNS &&
            !wrapped_to_line2) begin
          wrapped_to_line2 = 1'b1;
          plan_goto(2'd1, 8'd0);
        end else if (chars_in_string >= 2 * CLCD_COLUMNS) begin
          plan_byte(RS_CMD, cfg_clear_code);
          plan_goto(2'd0, 8'd0);
          chars_in_string = '0;
          wrapped_to_line2 = 1'b0;
        end
        chars_in_string = chars_in_string + 6'd1;
        plan_byte(RS_DATA, it.byte_value);
      end
      ACT_CMD:   plan_byte(RS_CMD, it.byte_value);
      ACT_CLEAR: begin
        plan_byte(RS_CMD, cfg_clear_code);
        plan_goto(2'd0, 8'd0);
      end
      default:   plan_goto(it.line_sel, it.column);
    endcase
    if (planned_len > 0) planned_xfers[planned_len - 1].last = 1'b1;
  endfunction

  function automatic lcd_item_t random_item();
    lcd_item_t it;
    it.action       = action_t'($urandom_range(3));
    it.byte_value   = 8'($urandom);
    it.line_sel     = 2'($urandom);
    it.column       = 8'($urandom);
    it.string_start = 1'($urandom);
    return it;
  endfunction

  // Register write: setup then access phase
  task automatic reg_write(input int unsigned idx, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = APB_AW'(idx << 2);
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BUS_MODE:    cfg_four_bit    = data[0];
      REG_FIRST_BASE:  cfg_first_base  = data[BYTE_W-1:0];
      REG_SECOND_BASE: cfg_second_base = data[BYTE_W-1:0];
      REG_CLEAR_CODE:  cfg_clear_code  = data[BYTE_W-1:0];
      REG_PULSE_TICKS: cfg_pulse_ticks = data[TICKS_W-1:0];
      REG_WAIT_TICKS:  cfg_wait_ticks  = data[TICKS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Read back every register and compare with the held copies
  task automatic check_regs();
    logic [APB_DW-1:0] got;
    logic [APB_DW-1:0] want;
    for (int unsigned i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = APB_AW'(i << 2);
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      got = prdata;
      case (i)
        REG_BUS_MODE:    want = 32'(cfg_four_bit);
        REG_FIRST_BASE:  want = 32'(cfg_first_base);
        REG_SECOND_BASE: want = 32'(cfg_second_base);
        REG_CLEAR_CODE:  want = 32'(cfg_clear_code);
        REG_PULSE_TICKS: want = 32'(cfg_pulse_ticks);
        default:         want = 32'(cfg_wait_ticks);
      endcase
      if (got !== want) begin
        errors++;
        $display("%0t: register %0d read mismatch: expected %08h, actual %08h",
                 $time, i, want, got);
      end
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  // Write all registers; junk in the upper bits must be dropped
  task automatic apply_settings(input logic bus, input logic [7:0] first,
                                input logic [7:0] second, input logic [7:0] clr,
                                input logic [15:0] pulse, input logic [15:0] wait_t);
    reg_write(REG_BUS_MODE,    ($urandom() << 1) | 32'(bus));
    reg_write(REG_FIRST_BASE,  ($urandom() << 8) | 32'(first));
    reg_write(REG_SECOND_BASE, ($urandom() << 8) | 32'(second));
    reg_write(REG_CLEAR_CODE,  ($urandom() << 8) | 32'(clr));
    reg_write(REG_PULSE_TICKS, ($urandom() << 16) | 32'(pulse));
    reg_write(REG_WAIT_TICKS,  ($urandom() << 16) | 32'(wait_t));
    check_regs();
  endtask

  // Offer one request, idling at random first; record expectations on acceptance
  task automatic send_item(input lcd_item_t it, input int row);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.action          = it.action;
    in_ch.byte_value      = it.byte_value;
    in_ch.line_select     = it.line_sel;
    in_ch.column_position = it.column;
    in_ch.string_start    = it.string_start;
    in_ch.valid           = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    plan_bus_transfers(it);
    if (planned_len > 0) productive_items++;
    if (row >= 0 && stim_table[row].n_typed != FROM_PREDICTOR) begin
      for (int k = 0; k < stim_table[row].n_typed; k++)
        pending_transfers.push_back(stim_table[row].typed[k]);
    end else begin
      for (int k = 0; k < planned_len; k++) pending_transfers.push_back(planned_xfers[k]);
    end
  endtask

  // Mostly well-formed strings of random length, with stray requests between them
  task automatic run_random(input int target);
    int base_count;
    int len;
    lcd_item_t it;
    logic first_start;
    base_count = productive_items;
    while (productive_items - base_count < target) begin
      if ($urandom_range(3) == 0) begin
        it = random_item();
        if (it.action == ACT_GOTO && $urandom_range(3) != 0) begin
          it.line_sel = 2'($urandom_range(1));
          it.column = 8'($urandom_range(CLCD_COLUMNS - 1));
        end
        send_item(it, -1);
      end else begin
        len = ($urandom_range(3) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 20);
        first_start = ($urandom_range(9) != 0);
        for (int k = 0; k < len; k++) begin
          it = random_item();
          it.action = ACT_CHAR;
          it.string_start = (k == 0) ? first_start : ($urandom_range(49) == 0);
          send_item(it, -1);
        end
      end
    end
  endtask

  // Drop valid, drain the owed transfers, then idle before the next phase
  task automatic settle();
    int waited;
    @(negedge clk);
    in_ch.valid = 1'b0;
    waited = 0;
    while (pending_transfers.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_transfers.size() != 0) begin
      errors += pending_transfers.size();
      $display("%0t: %0d expected transfers never arrived", $time, pending_transfers.size());
      pending_transfers.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != long_hold_seq) begin
        hold_seen = long_hold_seq;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Check each transfer transaction against the oldest expectation
  always @(posedge clk) begin
    xfer_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_transfers.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer rs=%0b bus=%02h last=%0b", $time,
                 out_ch.register_select, out_ch.bus_value, out_ch.last);
      end else begin
        want = pending_transfers.pop_front();
        if (out_ch.register_select !== want.rs || out_ch.bus_value !== want.value ||
            out_ch.last !== want.last) begin
          errors++;
          $display({"%0t: transfer mismatch: expected rs=%0b bus=%02h last=%0b, ",
                    "actual rs=%0b bus=%02h last=%0b"},
                   $time, want.rs, want.value, want.last,
                   out_ch.register_select, out_ch.bus_value, out_ch.last);
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_CHAR;
    in_ch.byte_value = '0;
    in_ch.line_select = '0;
    in_ch.column_position = '0;
    in_ch.string_start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    wait (rst_n === 1'b1);

    // reset defaults, directed table, then random items, no idling
    check_regs();
    foreach (stim_table[r]) send_item(stim_table[r].item, r);
    run_random(60);
    settle();

    // four-bit bus, random bases, sender idles
    apply_settings(1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom_range(1, 65535)), 16'($urandom));
    send_idle_pct = 49;
    run_random(60);
    settle();

    // top bases so addresses wrap; stray register indexes; receiver stalls
    apply_settings(1'b0, 8'hFF, 8'hFF, 8'h00, 16'd1, 16'd0);
    reg_write(NUM_REGS, $urandom());
    reg_write(NUM_REGS + 1, $urandom());
    check_regs();
    send_idle_pct = 0;
    recv_stall_pct = 49;
    run_random(60);
    settle();

    // zero bases, both sides idle
    apply_settings(1'b1, 8'h00, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    run_random(60);
    settle();

    // long receiver hold-off so the block backs up into its input
    apply_settings(1'b1, FIRST_BASE_RST, SECOND_BASE_RST, CLEAR_CODE_RST,
                   PULSE_TICKS_RST, WAIT_TICKS_RST);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_seq++;
    run_random(60);
    settle();

    if (errors == 0) begin
      $display("** char_lcd_write_sequencer: PASSED **");
    end else begin
      $display("** char_lcd_write_sequencer: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("** char_lcd_write_sequencer: FAILED **");
    $finish;
  end

endmodule
